// File: sv/icc_pkg.sv
// package: sizes, payload structs and table control struct for connected components
package icc_pkg;

    localparam int MAX_TERMS = 1024;
    localparam int TERM_BITS = 64;
    localparam int IDX_W     = $clog2(MAX_TERMS);
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int CID_W     = 11;
    localparam int SUM_W     = 21;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [63:0] term_a;
        logic [63:0] term_b;
    } icc_in_t;

    typedef struct packed {
        logic [CID_W-1:0] component_id;
        logic             merged;
        logic             created;
        logic             table_full;
        logic [SUM_W-1:0] pair_count;
    } icc_out_t;

    typedef struct packed {
        logic [IDX_W-1:0]     rd_addr;
        logic                 key_we;
        logic                 comp_we;
        logic [IDX_W-1:0]     wr_addr;
        logic [TERM_BITS-1:0] wr_key;
        logic [IDX_W-1:0]     wr_comp;
        logic [IDX_W-1:0]     size_raddr;
        logic                 size_we;
        logic [IDX_W-1:0]     size_waddr;
        logic [CNT_W-1:0]     size_wdata;
    } icc_tbl_ctrl_t;

endpackage

// File: sv/incremental_connected_components_top.sv
// top level: incremental connected components over a stream of edges
// s_ channel takes one beat per request: an edge (term_a, term_b) or a clear.
// m_ channel returns exactly one beat per request: component of term_a,
// merged / created / table_full flags and the sum of squared component sizes.
// terms sit in a table filled in order; each edge scans the used entries one
// per cycle through the registered memory port. a merge adds a second sweep
// over the used entries that rewrites the component of every member of
// term_b's component, plus a size update through ST_SZ1, ST_SZ2 and ST_SZ3.
// an insert writes its new terms in ST_DECIDE and ST_INS_B, or in ST_GROW.
// a clear goes from idle straight to ST_DONE. s_ready is high only while the
// sequencer is idle; one finished result may wait in the output register
// while the next request is accepted, and the sequencer holds its last state
// until m_ready frees that register. reset (aresetn low, synchronous) empties
// the table at once through the fill count; no clearing pass is needed.
module incremental_connected_components_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  icc_pkg::icc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output icc_pkg::icc_out_t m_data
);
    import icc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_DECIDE, ST_INS_B, ST_GROW,
        ST_RELABEL, ST_SZ1, ST_SZ2, ST_SZ3, ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [CNT_W-1:0]     ncomp_reg, ncomp_next;
    logic [SUM_W-1:0]     sq_reg, sq_next;
    logic [TERM_BITS-1:0] a_reg, a_next, b_reg, b_next;
    logic                 fa_reg, fa_next, fb_reg, fb_next;
    logic [IDX_W-1:0]     ca_reg, ca_next, cb_reg, cb_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     paddr_reg, paddr_next;
    logic [CNT_W-1:0]     s1_reg, s1_next;
    logic [2*CNT_W-1:0]   prod_reg, prod_next;
    icc_out_t             res_reg, res_next;
    logic                 mv_reg, mv_next;
    icc_out_t             md_reg, md_next;

    icc_tbl_ctrl_t        tbl;
    logic [TERM_BITS-1:0] rd_key;
    logic [IDX_W-1:0]     rd_comp;
    logic [CNT_W-1:0]     rd_size;

    logic                 same;
    logic [1:0]           need;
    logic [CNT_W-1:0]     room;
    logic [IDX_W-1:0]     newc;

    icc_tables u_tables (
        .aclk    (aclk),
        .ctrl    (tbl),
        .rd_key  (rd_key),
        .rd_comp (rd_comp),
        .rd_size (rd_size)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = md_reg;

    assign same = (a_reg == b_reg);
    assign need = {1'b0, !fa_reg} + {1'b0, (!fb_reg && !same)};
    assign room = CNT_W'(MAX_TERMS) - used_reg;
    assign newc = (ncomp_reg >= CNT_W'(MAX_TERMS)) ? IDX_W'(MAX_TERMS - 1)
                                                    : ncomp_reg[IDX_W-1:0];

    always_comb begin
        state_next = state_reg;
        used_next  = used_reg;
        ncomp_next = ncomp_reg;
        sq_next    = sq_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        fa_next    = fa_reg;
        fb_next    = fb_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        paddr_next = paddr_reg;
        s1_next    = s1_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;

        tbl            = '0;
        tbl.rd_addr    = idx_reg[IDX_W-1:0];
        tbl.wr_addr    = used_reg[IDX_W-1:0];
        tbl.wr_key     = a_reg;
        tbl.wr_comp    = newc;
        tbl.size_raddr = ca_reg;
        tbl.size_waddr = ca_reg;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    a_next   = s_data.term_a[TERM_BITS-1:0];
                    b_next   = s_data.term_b[TERM_BITS-1:0];
                    fa_next  = 1'b0;
                    fb_next  = 1'b0;
                    idx_next = '0;
                    res_next = '0;
                    if (s_data.req_type == REQ_CLEAR) begin
                        used_next  = '0;
                        ncomp_next = '0;
                        sq_next    = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (pend_reg) begin
                    if (!fa_reg && rd_key == a_reg) begin
                        fa_next = 1'b1;
                        ca_next = rd_comp;
                    end
                    if (!fb_reg && rd_key == b_reg) begin
                        fb_next = 1'b1;
                        cb_next = rd_comp;
                    end
                end
                if (idx_reg < used_reg) begin
                    pend_next = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end else if (!pend_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                res_next.pair_count = sq_reg;
                if (CNT_W'(need) > room) begin
                    res_next.table_full   = 1'b1;
                    res_next.component_id = fa_reg ? CID_W'(ca_reg) : CID_W'(MAX_TERMS);
                    state_next            = ST_DONE;
                end else if (!fa_reg && !fb_reg) begin
                    tbl.key_we     = 1'b1;
                    tbl.comp_we    = 1'b1;
                    tbl.size_we    = 1'b1;
                    tbl.size_waddr = newc;
                    tbl.size_wdata = same ? CNT_W'(1) : CNT_W'(2);
                    used_next      = used_reg + 1'b1;
                    ncomp_next     = CNT_W'(newc) + 1'b1;
                    ca_next        = newc;
                    sq_next        = sq_reg + (same ? SUM_W'(1) : SUM_W'(4));
                    res_next.created      = 1'b1;
                    res_next.component_id = CID_W'(newc);
                    res_next.pair_count   = sq_next;
                    state_next = same ? ST_DONE : ST_INS_B;
                end else if (!fa_reg || !fb_reg) begin
                    ca_next        = fa_reg ? ca_reg : cb_reg;
                    tbl.size_raddr = fa_reg ? ca_reg : cb_reg;
                    state_next     = ST_GROW;
                end else if (ca_reg == cb_reg) begin
                    res_next.component_id = CID_W'(ca_reg);
                    state_next            = ST_DONE;
                end else begin
                    idx_next   = '0;
                    state_next = ST_RELABEL;
                end
            end
            ST_INS_B: begin
                tbl.key_we  = 1'b1;
                tbl.comp_we = 1'b1;
                tbl.wr_key  = b_reg;
                tbl.wr_comp = ca_reg;
                used_next   = used_reg + 1'b1;
                state_next  = ST_DONE;
            end
            ST_GROW: begin
                tbl.key_we     = 1'b1;
                tbl.comp_we    = 1'b1;
                tbl.wr_key     = fa_reg ? b_reg : a_reg;
                tbl.wr_comp    = ca_reg;
                tbl.size_we    = 1'b1;
                tbl.size_wdata = rd_size + 1'b1;
                used_next      = used_reg + 1'b1;
                sq_next        = sq_reg + SUM_W'({rd_size, 1'b1});
                res_next.component_id = CID_W'(ca_reg);
                res_next.pair_count   = sq_next;
                state_next = ST_DONE;
            end
            ST_RELABEL: begin
                tbl.wr_addr = paddr_reg;
                tbl.wr_comp = ca_reg;
                if (pend_reg && rd_comp == cb_reg) begin
                    tbl.comp_we = 1'b1;
                end
                if (idx_reg < used_reg) begin
                    pend_next  = 1'b1;
                    paddr_next = idx_reg[IDX_W-1:0];
                    idx_next   = idx_reg + 1'b1;
                end else if (!pend_reg) begin
                    tbl.size_raddr = ca_reg;
                    state_next     = ST_SZ1;
                end
            end
            ST_SZ1: begin
                s1_next        = rd_size;
                tbl.size_raddr = cb_reg;
                state_next     = ST_SZ2;
            end
            ST_SZ2: begin
                prod_next      = s1_reg * rd_size;
                tbl.size_we    = 1'b1;
                tbl.size_wdata = s1_reg + rd_size;
                state_next     = ST_SZ3;
            end
            ST_SZ3: begin
                tbl.size_we    = 1'b1;
                tbl.size_waddr = cb_reg;
                tbl.size_wdata = '0;
                sq_next        = sq_reg + {prod_reg[SUM_W-2:0], 1'b0};
                res_next.merged       = 1'b1;
                res_next.component_id = CID_W'(ca_reg);
                res_next.pair_count   = sq_next;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    md_next    = res_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            ncomp_reg <= '0;
            sq_reg    <= '0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            ncomp_reg <= ncomp_next;
            sq_reg    <= sq_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
        end
        a_reg     <= a_next;
        b_reg     <= b_next;
        fa_reg    <= fa_next;
        fb_reg    <= fb_next;
        ca_reg    <= ca_next;
        cb_reg    <= cb_next;
        idx_reg   <= idx_next;
        paddr_reg <= paddr_next;
        s1_reg    <= s1_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
        md_reg    <= md_next;
    end

endmodule

// File: sv/icc_tables.sv
// term key, term component and component size memories
module icc_tables (
    input  logic                            aclk,
    input  icc_pkg::icc_tbl_ctrl_t          ctrl,
    output logic [icc_pkg::TERM_BITS-1:0]   rd_key,
    output logic [icc_pkg::IDX_W-1:0]       rd_comp,
    output logic [icc_pkg::CNT_W-1:0]       rd_size
);
    import icc_pkg::*;

    logic [TERM_BITS-1:0] key_mem  [MAX_TERMS];
    logic [IDX_W-1:0]     comp_mem [MAX_TERMS];
    logic [CNT_W-1:0]     size_mem [MAX_TERMS];

    always_ff @(posedge aclk) begin
        if (ctrl.key_we) begin
            key_mem[ctrl.wr_addr] <= ctrl.wr_key;
        end
        rd_key <= key_mem[ctrl.rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.comp_we) begin
            comp_mem[ctrl.wr_addr] <= ctrl.wr_comp;
        end
        rd_comp <= comp_mem[ctrl.rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.size_we) begin
            size_mem[ctrl.size_waddr] <= ctrl.size_wdata;
        end
        rd_size <= size_mem[ctrl.size_raddr];
    end

endmodule

// File: verif/incremental_connected_components_top_tb.sv
// testbench: edge stream against a behavioural component tracker, with table fill and stalls
module incremental_connected_components_top_tb;
    import icc_pkg::*;

    localparam int LIMIT = 4000000;

    typedef struct packed {
        logic     check_typed;
        icc_in_t  req;
        icc_out_t res;
    } edge_row_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    icc_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    icc_out_t m_data;

    logic [63:0] term_key [MAX_TERMS];
    int          term_comp [MAX_TERMS];
    int          comp_size [MAX_TERMS];
    int          next_comp;
    int          terms_used;
    longint      square_sum;

    icc_out_t    pending_results[$];
    logic [63:0] term_pool [48];
    edge_row_t   edge_rows [$];
    int          errors = 0;
    int          sent = 0;
    int          checked = 0;
    int          merges_seen = 0;
    int          fulls_seen = 0;
    int          cycles = 0;
    bit          long_hold = 1'b0;
    bit          sending_done = 1'b0;
    bit          fast_mode = 1'b0;

    always #6 aclk = ~aclk;

    incremental_connected_components_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    function automatic void clear_tracker();
        next_comp = 0;
        terms_used = 0;
        square_sum = 0;
        foreach (comp_size[i]) comp_size[i] = 0;
    endfunction

    function automatic int lookup_term(logic [63:0] key);
        for (int i = 0; i < terms_used; i++)
            if (term_key[i] == key) return i;
        return MAX_TERMS;
    endfunction

    function automatic void add_term(logic [63:0] key, int comp);
        if (terms_used < MAX_TERMS) begin
            term_key[terms_used] = key;
            term_comp[terms_used] = comp;
            terms_used++;
        end
    endfunction

    function automatic icc_out_t track_edge(icc_in_t req);
        icc_out_t r;
        int ia, ib, need, c, c1, c2;
        r = '0;
        if (req.req_type == REQ_CLEAR) begin
            clear_tracker();
            return r;
        end
        ia = lookup_term(req.term_a);
        ib = (req.term_b == req.term_a) ? ia : lookup_term(req.term_b);
        need = (ia == MAX_TERMS) + (ib == MAX_TERMS && req.term_b != req.term_a);
        if (need > MAX_TERMS - terms_used) begin
            r.table_full = 1'b1;
        end else if (ia == MAX_TERMS && ib == MAX_TERMS) begin
            c = (next_comp >= MAX_TERMS) ? MAX_TERMS - 1 : next_comp;
            next_comp = c + 1;
            add_term(req.term_a, c);
            comp_size[c] = 1;
            if (req.term_b != req.term_a) begin
                add_term(req.term_b, c);
                comp_size[c] = 2;
            end
            square_sum += comp_size[c] * comp_size[c];
            r.created = 1'b1;
        end else if (ib == MAX_TERMS || ia == MAX_TERMS) begin
            c = (ib == MAX_TERMS) ? term_comp[ia] : term_comp[ib];
            square_sum += 2 * comp_size[c] + 1;
            add_term((ib == MAX_TERMS) ? req.term_b : req.term_a, c);
            comp_size[c]++;
        end else begin
            c1 = term_comp[ia];
            c2 = term_comp[ib];
            if (c1 != c2) begin
                for (int i = 0; i < terms_used; i++)
                    if (term_comp[i] == c2) term_comp[i] = c1;
                square_sum += 2 * longint'(comp_size[c1]) * comp_size[c2];
                comp_size[c1] += comp_size[c2];
                comp_size[c2] = 0;
                r.merged = 1'b1;
            end
        end
        ia = lookup_term(req.term_a);
        r.component_id = (ia == MAX_TERMS) ? CID_W'(MAX_TERMS) : CID_W'(term_comp[ia]);
        r.pair_count = SUM_W'(square_sum);
        return r;
    endfunction

    function automatic icc_in_t make_edge(logic [63:0] a, logic [63:0] b);
        icc_in_t r;
        r.req_type = REQ_ADD;
        r.term_a = a;
        r.term_b = b;
        return r;
    endfunction

    function automatic icc_in_t make_clear();
        icc_in_t r;
        r.req_type = REQ_CLEAR;
        r.term_a = {$urandom, $urandom};
        r.term_b = {$urandom, $urandom};
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // drive one beat, predict on acceptance
    task automatic send_beat(icc_in_t req, bit typed, icc_out_t typed_res);
        icc_out_t predicted;
        bit accepted;
        if (!fast_mode) repeat (gap_len()) @(negedge aclk);
        s_data = req;
        s_valid = 1'b1;
        accepted = 1'b0;
        while (!accepted) begin
            @(posedge aclk);
            accepted = s_ready;
            if (accepted) begin
                predicted = track_edge(req);
                pending_results = {pending_results, (typed ? typed_res : predicted)};
                sent++;
            end
            @(negedge aclk);
        end
        s_valid = 1'b0;
    endtask

    task automatic send_edge(icc_in_t req);
        send_beat(req, 1'b0, '0);
    endtask

    function automatic void add_row(icc_in_t req, bit typed, int cid, bit mg, bit cr,
                                    bit fl, int pc);
        edge_row_t row;
        row.check_typed = typed;
        row.req = req;
        row.res = {CID_W'(cid), mg, cr, fl, SUM_W'(pc)};
        edge_rows = {edge_rows, row};
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout at %0t", $time);
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_data);
                errors++;
            end else begin
                icc_out_t e;
                e = pending_results.pop_front();
                checked++;
                if (m_data.merged) merges_seen++;
                if (m_data.table_full) fulls_seen++;
                if (m_data.component_id !== e.component_id)
                    $display("%0t: component_id expected %0d got %0d",
                             $time, e.component_id, m_data.component_id);
                if (m_data.merged !== e.merged)
                    $display("%0t: merged expected %0b got %0b", $time, e.merged,
                             m_data.merged);
                if (m_data.created !== e.created)
                    $display("%0t: created expected %0b got %0b", $time, e.created,
                             m_data.created);
                if (m_data.table_full !== e.table_full)
                    $display("%0t: table_full expected %0b got %0b", $time,
                             e.table_full, m_data.table_full);
                if (m_data.pair_count !== e.pair_count)
                    $display("%0t: pair_count expected %0d got %0d", $time,
                             e.pair_count, m_data.pair_count);
                if (m_data !== e) errors++;
            end
        end
    end

    // result side: random stalls, one long hold-off
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_ready = 1'b0;
                for (n = 0; n < 400; n++) @(negedge aclk);
                long_hold = 1'b0;
            end
            if (fast_mode) begin
                m_ready = 1'b1;
            end else begin
                n = gap_len();
                m_ready = (n == 0);
                for (int i = 1; i < n; i++) @(negedge aclk);
            end
        end
    end

    initial begin
        logic [63:0] top_term;
        int k, wait_cycles;
        clear_tracker();
        top_term = '1;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        add_row(make_edge(64'd0, 64'd0), 1, 0, 0, 1, 0, 1);
        add_row(make_edge(top_term, top_term - 1), 1, 1, 0, 1, 0, 5);
        add_row(make_edge(64'd0, top_term), 1, 0, 1, 0, 0, 9);
        add_row(make_edge(64'd0, top_term), 1, 0, 0, 0, 0, 9);
        add_row(make_edge(top_term, top_term), 1, 0, 0, 0, 0, 9);
        add_row(make_edge(64'd5, 64'd0), 1, 0, 0, 0, 0, 16);
        add_row(make_edge(64'd7, 64'd9), 1, 2, 0, 1, 0, 20);
        add_row(make_edge(64'd7, 64'd5), 1, 2, 1, 0, 0, 36);
        add_row(make_edge(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA), 0, 0, 0, 0, 0, 0);
        add_row(make_edge(64'h5555_5555_5555_5555, 64'd9), 0, 0, 0, 0, 0, 0);
        add_row(make_clear(), 1, 0, 0, 0, 0, 0);
        add_row(make_edge(64'h8000_0000_0000_0000, 64'd1), 1, 0, 0, 1, 0, 4);
        add_row(make_edge(64'd1, 64'd1), 1, 0, 0, 0, 0, 4);
        add_row(make_edge(64'd1, 64'd3), 1, 0, 0, 0, 0, 9);
        foreach (edge_rows[i])
            send_beat(edge_rows[i].req, edge_rows[i].check_typed, edge_rows[i].res);

        // random edges over a small term pool, refreshed on each clear
        foreach (term_pool[i]) term_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < 20; i++) begin
            if (i == 5) long_hold = 1'b1;
            k = $urandom_range(0, 99);
            if (k < 3) begin
                send_edge(make_clear());
                foreach (term_pool[j]) term_pool[j] = {$urandom, $urandom};
            end else if (k < 8) begin
                send_edge(make_edge({$urandom, $urandom},
                                    term_pool[$urandom_range(0, 47)]));
            end else begin
                send_edge(make_edge(term_pool[$urandom_range(0, 47)],
                                    term_pool[$urandom_range(0, 47)]));
            end
        end

        // fill the table, then a mix of edges that still fit and edges that no longer fit
        send_edge(make_clear());
        fast_mode = 1'b1;
        top_term = {$urandom, $urandom};
        for (int i = 0; i < MAX_TERMS / 2 - 1; i++)
            send_edge(make_edge(top_term + 2 * i, top_term + 2 * i + 1));
        fast_mode = 1'b0;
        send_edge(make_edge(64'd11, 64'd11));
        send_edge(make_edge(64'd12, 64'd12));
        send_edge(make_edge(top_term + 7, top_term));
        send_edge(make_edge(64'd11, top_term + 3));
        send_edge(make_edge(64'd13, 64'd14));
        send_edge(make_edge(top_term, 64'd15));
        send_edge(make_edge(64'd16, 64'd17));
        send_edge(make_edge(64'd11, 64'd12));
        send_edge(make_clear());
        send_edge(make_edge(64'd11, 64'd12));
        sending_done = 1'b1;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 200000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (2 * MAX_TERMS + 50) @(posedge aclk);

        $display("%0d requests sent, %0d results checked", sent, checked);
        $display("%0d merges and %0d table-full results seen", merges_seen, fulls_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pending_results.size());
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// File: sim.f
sv/icc_pkg.sv
sv/icc_tables.sv
sv/incremental_connected_components_top.sv
verif/incremental_connected_components_top_tb.sv
